@@ rtl/image_conv2d_reflect_border_assert.svh @@
// Assertion macros for the filter RTL.
// Both macros expect clk and rst to be visible where they are used.
`ifndef IMAGE_CONV2D_REFLECT_BORDER_ASSERT_SVH
`define IMAGE_CONV2D_REFLECT_BORDER_ASSERT_SVH

// same-cycle implication
`define ICRB_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ICRB_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/icrb_pkg.sv @@
// ----------------------------------------------------------------------------
// icrb_pkg
// Shared types and fixed constants of the 2-D convolution filter.
// ----------------------------------------------------------------------------
package icrb_pkg;

  localparam int FRAC_BITS     = 10;
  localparam int COEF_REG_W    = 60;
  localparam int NUM_COEF_ROWS = 5;
  localparam int KS_W          = 3;
  localparam int DIM_W         = 11;
  localparam int CFG_IDX_W     = 4;
  localparam int PIX_W         = 8;

  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_SIZE  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_ROW_0   = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_ROW_1   = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_ROW_2   = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_ROW_3   = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_ROW_4   = 4'd7;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  typedef struct packed {
    logic             op;
    logic [PIX_W-1:0] pixel_in;
  } in_word_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             end_of_row;
    logic             end_of_frame;
    logic             last_of_run;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_CHECK,
    ST_TAPS,
    ST_WAIT,
    ST_PRESENT
  } state_t;

  typedef struct packed {
    logic wr_go;
    logic tap_go;
    logic tap_clr;
  } dp_cmd_t;

  typedef struct packed {
    logic busy;
  } dp_stat_t;

endpackage

@@ rtl/icrb_dp.sv @@
// ----------------------------------------------------------------------------
// icrb_dp
// Datapath: border mirroring, line store, multiply-accumulate and rounding.
// ----------------------------------------------------------------------------
module icrb_dp #(
  parameter int MAX_KERNEL = 5,
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int COEF_BITS  = 12
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  icrb_pkg::dp_cmd_t                     cmd,
  output icrb_pkg::dp_stat_t                    stat,
  input  logic [icrb_pkg::KS_W-1:0]             tap_i,
  input  logic [icrb_pkg::KS_W-1:0]             tap_j,
  input  logic [$clog2(MAX_HEIGHT)-1:0]         oy,
  input  logic [$clog2(MAX_WIDTH)-1:0]          ox,
  input  logic [$clog2(MAX_HEIGHT)-1:0]         wr_row,
  input  logic [$clog2(MAX_WIDTH)-1:0]          wr_col,
  input  logic [icrb_pkg::PIX_W-1:0]            wr_pix,
  input  logic [1:0]                            pad,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]        w,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0]       h,
  input  logic [icrb_pkg::COEF_REG_W-1:0]       coef_rows [icrb_pkg::NUM_COEF_ROWS],
  output logic [icrb_pkg::PIX_W-1:0]            res_pix
);

  localparam int RB    = $clog2(MAX_HEIGHT);
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int MS    = ((RB > CW) ? RB : CW) + 3;
  localparam int SH    = RB + 3;
  localparam int RECIP = (1 << SH) / MAX_KERNEL;
  localparam int PW    = RB + SH + 1;
  localparam int QW    = RB + 3;
  localparam int SLW   = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
  localparam int DEPTH = MAX_KERNEL * MAX_WIDTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int PRW   = COEF_BITS + 9;
  localparam int ACC_W = PRW + $clog2(MAX_KERNEL * MAX_KERNEL) + 1;
  localparam int FB    = icrb_pkg::FRAC_BITS;
  localparam int RQW   = ACC_W - FB + 1;

  localparam logic signed [MS-1:0] ONE_S = MS'(1);

  function automatic logic signed [MS-1:0] mirror(input logic signed [MS-1:0] p,
                                                  input logic signed [MS-1:0] n);
    logic signed [MS-1:0] t;
    t = p;
    if (t < 0) t = ~t;
    if (t >= n) t = (n <<< 1) + ~t;
    if (t < 0) t = '0;
    if (t >= n) t = n - ONE_S;
    return t;
  endfunction

  // stage A: mirrored position and coefficient
  logic                        va_rd, va_wr, a_clr;
  logic [RB-1:0]               a_row;
  logic [CW-1:0]               a_col;
  logic signed [COEF_BITS-1:0] a_coef;
  logic [icrb_pkg::PIX_W-1:0]  a_pix;

  logic signed [MS-1:0]        prow, pcol;
  logic [63:0]                 crow;
  logic [63:0]                 cfield;
  int                          sh_amt;

  always_comb begin
    prow = $signed(MS'(oy)) - $signed(MS'(pad)) + $signed(MS'(tap_i));
    pcol = $signed(MS'(ox)) - $signed(MS'(pad)) + $signed(MS'(tap_j));
    crow = '0;
    if (int'(tap_i) < icrb_pkg::NUM_COEF_ROWS) begin
      crow = 64'(coef_rows[tap_i[2:0]]);
    end
    sh_amt = int'(tap_j) * COEF_BITS;
    cfield = (sh_amt >= 64) ? 64'd0 : (crow >> sh_amt);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va_rd <= 1'b0;
      va_wr <= 1'b0;
    end else begin
      va_rd <= cmd.tap_go;
      va_wr <= cmd.wr_go;
    end
    a_clr <= cmd.tap_clr;
    a_pix <= wr_pix;
    if (cmd.wr_go) begin
      a_row <= wr_row;
      a_col <= wr_col;
    end else begin
      a_row <= RB'(mirror(prow, $signed(MS'(h))));
      a_col <= CW'(mirror(pcol, $signed(MS'(w))));
    end
    a_coef <= $signed(cfield[COEF_BITS-1:0]);
  end

  // stage B: quotient estimate of row / MAX_KERNEL
  logic                        vb_rd, vb_wr, b_clr;
  logic [RB-1:0]               b_row, b_q;
  logic [CW-1:0]               b_col;
  logic signed [COEF_BITS-1:0] b_coef;
  logic [icrb_pkg::PIX_W-1:0]  b_pix;
  logic [PW-1:0]               qprod;

  assign qprod = PW'(a_row) * PW'(RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      vb_rd <= 1'b0;
      vb_wr <= 1'b0;
    end else begin
      vb_rd <= va_rd;
      vb_wr <= va_wr;
    end
    b_clr  <= a_clr;
    b_row  <= a_row;
    b_col  <= a_col;
    b_coef <= a_coef;
    b_pix  <= a_pix;
    b_q    <= RB'(qprod >> SH);
  end

  // stage C: slot and store address; estimate is at most one low
  logic                        vc_rd, vc_wr, c_clr;
  logic [AW-1:0]               c_addr;
  logic signed [COEF_BITS-1:0] c_coef;
  logic [icrb_pkg::PIX_W-1:0]  c_pix;
  logic [QW-1:0]               rem;
  logic [SLW-1:0]              slot;

  always_comb begin
    rem = QW'(b_row) - QW'(b_q) * QW'(MAX_KERNEL);
    if (rem >= QW'(MAX_KERNEL)) rem = rem - QW'(MAX_KERNEL);
    slot = SLW'(rem);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vc_rd <= 1'b0;
      vc_wr <= 1'b0;
    end else begin
      vc_rd <= vb_rd;
      vc_wr <= vb_wr;
    end
    c_clr  <= b_clr;
    c_coef <= b_coef;
    c_pix  <= b_pix;
    c_addr <= AW'(slot) * AW'(MAX_WIDTH) + AW'(b_col);
  end

  // stage D: line store access
  logic [icrb_pkg::PIX_W-1:0]  line_mem [DEPTH];
  logic [icrb_pkg::PIX_W-1:0]  rd;
  logic                        vd_rd, d_clr;
  logic signed [COEF_BITS-1:0] d_coef;

  always_ff @(posedge clk) begin
    if (vc_wr) begin
      line_mem[c_addr] <= c_pix;
    end
    rd <= line_mem[c_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vd_rd <= 1'b0;
    end else begin
      vd_rd <= vc_rd;
    end
    d_clr  <= c_clr;
    d_coef <= c_coef;
  end

  // stage E: product
  logic                  ve, e_clr;
  logic signed [PRW-1:0] e_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      ve <= 1'b0;
    end else begin
      ve <= vd_rd;
    end
    e_clr  <= d_clr;
    e_prod <= $signed(PRW'({1'b0, rd})) * PRW'(d_coef);
  end

  // stage F: accumulate
  logic signed [ACC_W-1:0] acc;

  always_ff @(posedge clk) begin
    if (ve) begin
      acc <= e_clr ? ACC_W'(e_prod) : acc + ACC_W'(e_prod);
    end
  end

  assign stat.busy = va_rd | va_wr | vb_rd | vb_wr | vc_rd | vc_wr | vd_rd | ve;

  // round half to even, clamp to pixel range
  logic signed [RQW-1:0] q;
  logic [FB-1:0]         frac;
  logic                  up;

  always_comb begin
    q    = RQW'(acc >>> FB);
    frac = acc[FB-1:0];
    up   = (frac > FB'(1 << (FB - 1))) || ((frac == FB'(1 << (FB - 1))) && q[0]);
    q    = q + $signed(RQW'(up));
    if (q < 0) begin
      res_pix = '0;
    end else if (q > $signed(RQW'(255))) begin
      res_pix = 8'd255;
    end else begin
      res_pix = q[icrb_pkg::PIX_W-1:0];
    end
  end

endmodule

@@ rtl/icrb_ctrl.sv @@
// ----------------------------------------------------------------------------
// icrb_ctrl
// Controller: raster counters, item sequencing and result handshake.
// ----------------------------------------------------------------------------
`include "image_conv2d_reflect_border_assert.svh"

module icrb_ctrl #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  icrb_pkg::in_word_t                in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output icrb_pkg::out_word_t               out_data,
  input  logic [icrb_pkg::KS_W-1:0]         k,
  input  logic [1:0]                        pad,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]    w,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0]   h,
  output icrb_pkg::dp_cmd_t                 cmd,
  input  icrb_pkg::dp_stat_t                stat,
  output logic [icrb_pkg::KS_W-1:0]         tap_i,
  output logic [icrb_pkg::KS_W-1:0]         tap_j,
  output logic [$clog2(MAX_HEIGHT)-1:0]     oy,
  output logic [$clog2(MAX_WIDTH)-1:0]      ox,
  output logic [$clog2(MAX_HEIGHT)-1:0]     wr_row,
  output logic [$clog2(MAX_WIDTH)-1:0]      wr_col,
  output logic [icrb_pkg::PIX_W-1:0]        wr_pix,
  input  logic [icrb_pkg::PIX_W-1:0]        res_pix
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RB = $clog2(MAX_HEIGHT);
  localparam int RW = $clog2(MAX_HEIGHT + 3);

  icrb_pkg::state_t state, state_next;

  logic [CW-1:0]              in_col, in_col_next, cur_c, cur_c_next, ox_r, ox_next;
  logic [RW-1:0]              in_row, in_row_next, cur_r, cur_r_next;
  logic [icrb_pkg::KS_W-1:0]  ti, ti_next, tj, tj_next;
  logic [icrb_pkg::PIX_W-1:0] pix, pix_next;

  logic [CW-1:0] wm1, c_now;
  logic [RW-1:0] hpm1, r_now;
  logic          drain_now, accept, last;

  assign wm1       = CW'(w - 1'b1);
  assign hpm1      = RW'(h) + RW'(pad) - 1'b1;
  assign c_now     = (in_col > wm1) ? wm1 : in_col;
  assign r_now     = (in_row > hpm1) ? hpm1 : in_row;
  assign drain_now = r_now >= RW'(h);
  assign in_stall  = (state != icrb_pkg::ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign last      = (cur_c != wm1) || (ox_r == wm1);

  assign tap_i  = ti;
  assign tap_j  = tj;
  assign ox     = ox_r;
  assign oy     = RB'(cur_r - RW'(pad));
  assign wr_row = RB'(cur_r);
  assign wr_col = cur_c;
  assign wr_pix = pix;

  assign out_data.pixel_out    = res_pix;
  assign out_data.end_of_row   = (ox_r == wm1);
  assign out_data.end_of_frame = (ox_r == wm1) && (oy == RB'(h - 1'b1));
  assign out_data.last_of_run  = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= icrb_pkg::ST_IDLE;
      in_col <= '0;
      in_row <= '0;
    end else begin
      state  <= state_next;
      in_col <= in_col_next;
      in_row <= in_row_next;
    end
    cur_c <= cur_c_next;
    cur_r <= cur_r_next;
    ox_r  <= ox_next;
    ti    <= ti_next;
    tj    <= tj_next;
    pix   <= pix_next;
  end

  always_comb begin
    state_next  = state;
    in_col_next = in_col;
    in_row_next = in_row;
    cur_c_next  = cur_c;
    cur_r_next  = cur_r;
    ox_next     = ox_r;
    ti_next     = ti;
    tj_next     = tj;
    pix_next    = pix;
    cmd         = '0;
    out_valid   = 1'b0;
    case (state)
      icrb_pkg::ST_IDLE: begin
        // a drain word while image rows are still due is dropped
        if (accept && !(in_data.op == icrb_pkg::OP_DRAIN && !drain_now)) begin
          cur_c_next = c_now;
          cur_r_next = r_now;
          pix_next   = in_data.pixel_in;
          if (c_now >= wm1) begin
            in_col_next = '0;
            in_row_next = (r_now >= hpm1) ? '0 : r_now + 1'b1;
          end else begin
            in_col_next = c_now + 1'b1;
            in_row_next = r_now;
          end
          state_next = drain_now ? icrb_pkg::ST_CHECK : icrb_pkg::ST_WRITE;
        end
      end
      icrb_pkg::ST_WRITE: begin
        cmd.wr_go  = 1'b1;
        state_next = icrb_pkg::ST_CHECK;
      end
      icrb_pkg::ST_CHECK: begin
        if (cur_r >= RW'(pad) && cur_c >= CW'(pad)) begin
          ox_next    = cur_c - CW'(pad);
          ti_next    = '0;
          tj_next    = '0;
          state_next = icrb_pkg::ST_TAPS;
        end else begin
          state_next = icrb_pkg::ST_IDLE;
        end
      end
      icrb_pkg::ST_TAPS: begin
        cmd.tap_go  = 1'b1;
        cmd.tap_clr = (ti == '0) && (tj == '0);
        if (tj == k - 1'b1) begin
          tj_next = '0;
          if (ti == k - 1'b1) begin
            state_next = icrb_pkg::ST_WAIT;
          end else begin
            ti_next = ti + 1'b1;
          end
        end else begin
          tj_next = tj + 1'b1;
        end
      end
      icrb_pkg::ST_WAIT: begin
        if (!stat.busy) begin
          state_next = icrb_pkg::ST_PRESENT;
        end
      end
      icrb_pkg::ST_PRESENT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          if (last) begin
            state_next = icrb_pkg::ST_IDLE;
          end else begin
            // last column of the row: flush the right border outputs
            ox_next    = ox_r + 1'b1;
            ti_next    = '0;
            tj_next    = '0;
            state_next = icrb_pkg::ST_TAPS;
          end
        end
      end
      default: begin
        state_next = icrb_pkg::ST_IDLE;
      end
    endcase
  end

  `ICRB_ASSERT_NXT(a_wait_to_present, (state == icrb_pkg::ST_WAIT) && !stat.busy, out_valid, "result not presented after pipeline drained")
  `ICRB_ASSERT_IMP(a_tap_in_kernel, cmd.tap_go, (ti < k) && (tj < k), "tap index outside kernel")
  `ICRB_ASSERT_NXT(a_pixel_written, accept && !drain_now && (in_data.op == icrb_pkg::OP_PIXEL), cmd.wr_go, "image pixel not written to line store")

endmodule

@@ rtl/image_conv2d_reflect_border.sv @@
// ----------------------------------------------------------------------------
// image_conv2d_reflect_border
// Streaming 2-D convolution of 8-bit pixels with mirrored image borders.
// ----------------------------------------------------------------------------
// channel  direction  handshake               payload
// in       input      in_valid / in_stall     in_data  (op, pixel_in)
// out      output     out_valid / out_stall   out_data (pixel_out, flags)
// cfg      input      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One word at a time: accept, line store write (image rows only), check, then
// for each result the k*k taps, the pipeline drain and the output handshake.
// A drain word inside the image is accepted and dropped. The single-port line
// store and the one shared multiplier set the rate. Reset (rst, synchronous)
// clears the raster counters and state; line store contents stay undefined.
// out_stall holds the result; in_stall is high whenever a word is in flight.
module image_conv2d_reflect_border #(
  parameter int MAX_KERNEL = 5,
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int COEF_BITS  = 12
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  icrb_pkg::in_word_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output icrb_pkg::out_word_t                out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [icrb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [icrb_pkg::COEF_REG_W-1:0]    cfg_data
);

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int RB   = $clog2(MAX_HEIGHT);
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int HW   = $clog2(MAX_HEIGHT + 1);
  localparam int DWW  = (WW > icrb_pkg::DIM_W) ? WW : icrb_pkg::DIM_W;
  localparam int DHW  = (HW > icrb_pkg::DIM_W) ? HW : icrb_pkg::DIM_W;
  localparam int CAP0 = (MAX_KERNEL < 5) ? MAX_KERNEL : 5;
  localparam int CAP  = (CAP0 % 2 == 0) ? CAP0 - 1 : CAP0;

  logic [icrb_pkg::KS_W-1:0]       ks_reg;
  logic [icrb_pkg::DIM_W-1:0]      width_reg, height_reg;
  logic [icrb_pkg::COEF_REG_W-1:0] coef_reg [icrb_pkg::NUM_COEF_ROWS];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ks_reg     <= icrb_pkg::KS_W'(3);
      width_reg  <= icrb_pkg::DIM_W'(640);
      height_reg <= icrb_pkg::DIM_W'(480);
      for (int r = 0; r < icrb_pkg::NUM_COEF_ROWS; r++) begin
        coef_reg[r] <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        icrb_pkg::REG_KERNEL_SIZE:  ks_reg      <= cfg_data[icrb_pkg::KS_W-1:0];
        icrb_pkg::REG_IMAGE_WIDTH:  width_reg   <= cfg_data[icrb_pkg::DIM_W-1:0];
        icrb_pkg::REG_IMAGE_HEIGHT: height_reg  <= cfg_data[icrb_pkg::DIM_W-1:0];
        icrb_pkg::REG_COEF_ROW_0:   coef_reg[0] <= cfg_data;
        icrb_pkg::REG_COEF_ROW_1:   coef_reg[1] <= cfg_data;
        icrb_pkg::REG_COEF_ROW_2:   coef_reg[2] <= cfg_data;
        icrb_pkg::REG_COEF_ROW_3:   coef_reg[3] <= cfg_data;
        icrb_pkg::REG_COEF_ROW_4:   coef_reg[4] <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective kernel side: even sizes round up, capped at the largest odd fit
  logic [icrb_pkg::KS_W-1:0] k_odd, k;
  logic [1:0]                pad;
  logic [DWW-1:0]            wx;
  logic [DHW-1:0]            hx;
  logic [WW-1:0]             w;
  logic [HW-1:0]             h;

  always_comb begin
    k_odd = ks_reg | icrb_pkg::KS_W'(1);
    k     = (k_odd > icrb_pkg::KS_W'(CAP)) ? icrb_pkg::KS_W'(CAP) : k_odd;
    pad   = 2'(k >> 1);
    wx    = DWW'(width_reg);
    hx    = DHW'(height_reg);
    if (wx < DWW'(3)) w = WW'(3);
    else if (wx > DWW'(MAX_WIDTH)) w = WW'(MAX_WIDTH);
    else w = WW'(wx);
    if (hx < DHW'(3)) h = HW'(3);
    else if (hx > DHW'(MAX_HEIGHT)) h = HW'(MAX_HEIGHT);
    else h = HW'(hx);
  end

  icrb_pkg::dp_cmd_t          cmd;
  icrb_pkg::dp_stat_t         stat;
  logic [icrb_pkg::KS_W-1:0]  tap_i, tap_j;
  logic [RB-1:0]              oy, wr_row;
  logic [CW-1:0]              ox, wr_col;
  logic [icrb_pkg::PIX_W-1:0] wr_pix, res_pix;

  icrb_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .k         (k),
    .pad       (pad),
    .w         (w),
    .h         (h),
    .cmd       (cmd),
    .stat      (stat),
    .tap_i     (tap_i),
    .tap_j     (tap_j),
    .oy        (oy),
    .ox        (ox),
    .wr_row    (wr_row),
    .wr_col    (wr_col),
    .wr_pix    (wr_pix),
    .res_pix   (res_pix)
  );

  icrb_dp #(
    .MAX_KERNEL (MAX_KERNEL),
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .COEF_BITS  (COEF_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .tap_i     (tap_i),
    .tap_j     (tap_j),
    .oy        (oy),
    .ox        (ox),
    .wr_row    (wr_row),
    .wr_col    (wr_col),
    .wr_pix    (wr_pix),
    .pad       (pad),
    .w         (w),
    .h         (h),
    .coef_rows (coef_reg),
    .res_pix   (res_pix)
  );

endmodule
